@@ design/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// skt_pkg
// shared types, sizes and codes for the sorted key table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

    localparam int DEPTH       = 64;
    localparam int KEY_BITS    = 32;
    localparam int HANDLE_BITS = 32;
    localparam int SEQ_BITS    = 32;
    localparam int REFUSE_BITS = 32;
    localparam int OP_W        = 2;
    localparam int POS_W       = 6;
    localparam int STATUS_W    = 3;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int SLOT_W      = $clog2(DEPTH + 1);

    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    localparam logic [STATUS_W-1:0] STS_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STS_INVALID = 3'd1;
    localparam logic [STATUS_W-1:0] STS_DUP     = 3'd2;
    localparam logic [STATUS_W-1:0] STS_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] STS_MISS    = 3'd4;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]        operation;
        logic [KEY_BITS-1:0]    key;
        logic [HANDLE_BITS-1:0] handle;
        logic                   handle_ok;
        logic [POS_W-1:0]       position;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [SLOT_W-1:0]      slot;
        logic [KEY_BITS-1:0]    key_out;
        logic [HANDLE_BITS-1:0] handle_out;
        logic [SEQ_BITS-1:0]    seq_out;
        logic [SLOT_W-1:0]      entry_count;
        logic [REFUSE_BITS-1:0] refused_count;
    } rsp_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]    key;
        logic [HANDLE_BITS-1:0] handle;
        logic [SEQ_BITS-1:0]    seq;
    } entry_t;

    // ge: cell is at or past the insert point, eq: key match, sel: chosen for readout
    typedef struct packed {
        logic ge;
        logic eq;
        logic sel;
    } cell_flags_t;

endpackage

`default_nettype wire

@@ design/skt_cell.sv @@
// ----------------------------------------------------------------------------
// skt_cell
// one table position: holds an entry, compares it and shifts it up on insert
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skt_cell (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         load,
    input  wire logic                         commit,
    input  wire logic [skt_pkg::OP_W-1:0]     op,
    input  wire logic [skt_pkg::KEY_BITS-1:0] key,
    input  wire logic [skt_pkg::POS_W-1:0]    position,
    input  wire logic [skt_pkg::SLOT_W-1:0]   used,
    input  wire logic [skt_pkg::IDX_W-1:0]    cell_index,
    input  wire logic                         prev_ge,
    input  wire skt_pkg::entry_t              prev_entry,
    input  wire skt_pkg::entry_t              new_entry,
    output skt_pkg::entry_t                   entry,
    output skt_pkg::cell_flags_t              flags
);

    skt_pkg::entry_t      entry_reg;
    skt_pkg::entry_t      entry_next;
    skt_pkg::cell_flags_t flags_reg;
    skt_pkg::cell_flags_t flags_next;
    logic                 occupied;

    assign occupied = skt_pkg::SLOT_W'(cell_index) < used;

    always_comb
    begin
        flags_next.ge  = !(occupied && (entry_reg.key < key));
        flags_next.eq  = occupied && (entry_reg.key == key);
        if (op == skt_pkg::OP_READ)
        begin
            flags_next.sel = skt_pkg::SLOT_W'(cell_index) == skt_pkg::SLOT_W'(position);
        end
        else
        begin
            flags_next.sel = flags_next.eq;
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (commit && flags_reg.ge)
        begin
            entry_next = prev_ge ? prev_entry : new_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (load)
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign flags = flags_reg;

endmodule

`default_nettype wire

@@ design/skt_select.sv @@
// ----------------------------------------------------------------------------
// skt_select
// turns the cell flags into the insert position, a match bit and the chosen entry
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skt_select (
    input  wire skt_pkg::cell_flags_t         flags [skt_pkg::DEPTH],
    input  wire skt_pkg::entry_t              entries [skt_pkg::DEPTH],
    output logic                              match,
    output logic [skt_pkg::SLOT_W-1:0]        slot,
    output skt_pkg::entry_t                   chosen
);

    logic any_ge;
    logic hit;

    always_comb
    begin
        match  = 1'b0;
        any_ge = 1'b0;
        hit    = 1'b0;
        slot   = '0;
        chosen = '0;
        for (int i = 0; i < skt_pkg::DEPTH; i++)
        begin
            match  = match | flags[i].eq;
            any_ge = any_ge | flags[i].ge;
            if (i == 0)
            begin
                hit = flags[i].ge;
            end
            else
            begin
                hit = flags[i].ge && !flags[i-1].ge;
            end
            if (hit)
            begin
                slot = slot | skt_pkg::SLOT_W'(i);
            end
            if (flags[i].sel)
            begin
                chosen = chosen | entries[i];
            end
        end
        // every stored key below the search key
        if (!any_ge)
        begin
            slot = skt_pkg::SLOT_W'(skt_pkg::DEPTH);
        end
    end

endmodule

`default_nettype wire

@@ design/sorted_key_table.sv @@
// ----------------------------------------------------------------------------
// sorted_key_table
// response: registered, valid once the EXEC state has fired; later while an
// earlier response is still stalled
// one transaction at a time; the compare in the accept cycle and the insert
// shift in the EXEC state both work on the whole cell chain
// reset: entry count, sequence and refusal counters clear; entries undefined
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire skt_pkg::req_t  req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output skt_pkg::rsp_t       rsp
);

    skt_pkg::state_t                   state_reg;
    skt_pkg::state_t                   state_next;
    skt_pkg::req_t                     req_reg;
    skt_pkg::rsp_t                     rsp_reg;
    skt_pkg::rsp_t                     rsp_next;
    logic                              rsp_valid_reg;
    logic                              rsp_valid_next;
    logic [skt_pkg::SLOT_W-1:0]        used_reg;
    logic [skt_pkg::SLOT_W-1:0]        used_next;
    logic [skt_pkg::SEQ_BITS-1:0]      seq_reg;
    logic [skt_pkg::SEQ_BITS-1:0]      seq_next;
    logic [skt_pkg::REFUSE_BITS-1:0]   refused_reg;
    logic [skt_pkg::REFUSE_BITS-1:0]   refused_next;

    logic                              accept;
    logic                              fire;
    logic                              commit;
    logic                              match;
    logic [skt_pkg::SLOT_W-1:0]        ins_slot;
    skt_pkg::entry_t                   chosen;
    skt_pkg::entry_t                   new_entry;
    skt_pkg::entry_t                   entries [skt_pkg::DEPTH];
    skt_pkg::cell_flags_t              flags [skt_pkg::DEPTH];

    assign req_stall = (state_reg != skt_pkg::ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign fire      = (state_reg == skt_pkg::ST_EXEC) && (!rsp_valid_reg || !rsp_stall);

    assign new_entry = {req_reg.key, req_reg.handle, seq_reg};

    for (genvar i = 0; i < skt_pkg::DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            skt_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .load       (accept),
                .commit     (commit),
                .op         (req.operation),
                .key        (req.key),
                .position   (req.position),
                .used       (used_reg),
                .cell_index (skt_pkg::IDX_W'(i)),
                .prev_ge    (1'b0),
                .prev_entry (new_entry),
                .new_entry  (new_entry),
                .entry      (entries[i]),
                .flags      (flags[i])
            );
        end
        else
        begin : g_body
            skt_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .load       (accept),
                .commit     (commit),
                .op         (req.operation),
                .key        (req.key),
                .position   (req.position),
                .used       (used_reg),
                .cell_index (skt_pkg::IDX_W'(i)),
                .prev_ge    (flags[i-1].ge),
                .prev_entry (entries[i-1]),
                .new_entry  (new_entry),
                .entry      (entries[i]),
                .flags      (flags[i])
            );
        end
    end

    skt_select u_select (
        .flags   (flags),
        .entries (entries),
        .match   (match),
        .slot    (ins_slot),
        .chosen  (chosen)
    );

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        used_next      = used_reg;
        seq_next       = seq_reg;
        refused_next   = refused_reg;
        commit         = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            skt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = skt_pkg::ST_EXEC;
                end
            end
            skt_pkg::ST_EXEC:
            begin
                if (fire)
                begin
                    rsp_next.status     = skt_pkg::STS_MISS;
                    rsp_next.slot       = '0;
                    rsp_next.key_out    = '0;
                    rsp_next.handle_out = '0;
                    rsp_next.seq_out    = '0;
                    case (req_reg.operation)
                        skt_pkg::OP_ADD:
                        begin
                            if (!req_reg.handle_ok)
                            begin
                                rsp_next.status = skt_pkg::STS_INVALID;
                            end
                            else
                            begin
                                seq_next      = seq_reg + 1'b1;
                                rsp_next.slot = ins_slot;
                                if (match)
                                begin
                                    rsp_next.status     = skt_pkg::STS_DUP;
                                    rsp_next.key_out    = chosen.key;
                                    rsp_next.handle_out = chosen.handle;
                                    rsp_next.seq_out    = chosen.seq;
                                end
                                else if (used_reg == skt_pkg::SLOT_W'(skt_pkg::DEPTH))
                                begin
                                    rsp_next.status = skt_pkg::STS_FULL;
                                    refused_next    = refused_reg + 1'b1;
                                end
                                else
                                begin
                                    commit              = 1'b1;
                                    used_next           = used_reg + 1'b1;
                                    rsp_next.status     = skt_pkg::STS_OK;
                                    rsp_next.key_out    = new_entry.key;
                                    rsp_next.handle_out = new_entry.handle;
                                    rsp_next.seq_out    = new_entry.seq;
                                end
                            end
                        end
                        skt_pkg::OP_FIND:
                        begin
                            rsp_next.slot = ins_slot;
                            if (match)
                            begin
                                rsp_next.status     = skt_pkg::STS_OK;
                                rsp_next.key_out    = chosen.key;
                                rsp_next.handle_out = chosen.handle;
                                rsp_next.seq_out    = chosen.seq;
                            end
                        end
                        skt_pkg::OP_READ:
                        begin
                            rsp_next.slot = skt_pkg::SLOT_W'(req_reg.position);
                            if (skt_pkg::SLOT_W'(req_reg.position) < used_reg)
                            begin
                                rsp_next.status     = skt_pkg::STS_OK;
                                rsp_next.key_out    = chosen.key;
                                rsp_next.handle_out = chosen.handle;
                                rsp_next.seq_out    = chosen.seq;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = skt_pkg::STS_MISS;
                        end
                    endcase
                    rsp_next.entry_count   = used_next;
                    rsp_next.refused_count = refused_next;
                    rsp_valid_next         = 1'b1;
                    state_next             = skt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = skt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skt_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
            used_reg      <= '0;
            seq_reg       <= '0;
            refused_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            used_reg      <= used_next;
            seq_reg       <= seq_next;
            refused_reg   <= refused_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

@@ design/skt_checker.sv @@
// ----------------------------------------------------------------------------
// skt_checker
// port level checks for the sorted key table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skt_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    input  wire logic           req_stall,
    input  wire skt_pkg::req_t  req,
    input  wire logic           rsp_valid,
    input  wire logic           rsp_stall,
    input  wire skt_pkg::rsp_t  rsp
);

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // one transaction in flight: request side closes right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted back to back");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.entry_count <= skt_pkg::SLOT_W'(skt_pkg::DEPTH))
        else $error("entry count beyond depth");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == skt_pkg::STS_FULL
            |-> rsp.entry_count == skt_pkg::SLOT_W'(skt_pkg::DEPTH))
        else $error("full status with free room");

    a_invalid_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == skt_pkg::STS_INVALID
            |-> rsp.slot == '0 && rsp.key_out == '0 && rsp.seq_out == '0)
        else $error("invalid add reported entry data");

endmodule

bind sorted_key_table skt_checker u_skt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
